### hw/rtl/tscg_pkg.sv
// ----------------------------------------------------------------------------
// tscg_pkg
// Shared types, constants and the quarter-wave sine builder for the timed
// sine command generator.
// ----------------------------------------------------------------------------
package tscg_pkg;

	localparam int PERIOD_W     = 20;
	localparam int CMD_W        = 32;
	localparam int JOINT_W      = 3;
	localparam int COUNT_W      = 4;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 32;
	localparam int PHASE_W      = 48;
	localparam int THETA_HI_W   = 16;

	localparam int MAX_JOINTS   = 8;
	localparam int RESULT_SLOTS = 8;
	localparam int JOINT_LIMIT  = (MAX_JOINTS < RESULT_SLOTS) ? MAX_JOINTS : RESULT_SLOTS;

	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'd1073741824;

	localparam logic signed [31:0] CMD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] CMD_MIN = 32'sh8000_0000;

	localparam logic signed [23:0] AMPLITUDE_RST  = 24'sd1000;
	localparam logic [31:0]        FREQ_STEP_RST  = 32'd14073749;
	localparam logic signed [31:0] OFFSET_RST     = 32'sd0;
	localparam logic [15:0]        START_PHASE_RST = 16'd0;
	localparam logic [31:0]        RUN_LIMIT_RST  = 32'd0;
	localparam logic [JOINT_W-1:0] ACTIVE_JOINT_RST = 3'd0;
	localparam logic [COUNT_W-1:0] JOINT_COUNT_RST  = 4'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AMPLITUDE    = 3'd0,
		REG_FREQ_STEP    = 3'd1,
		REG_OFFSET       = 3'd2,
		REG_START_PHASE  = 3'd3,
		REG_RUN_LIMIT    = 3'd4,
		REG_ACTIVE_JOINT = 3'd5,
		REG_JOINT_COUNT  = 3'd6
	} cfg_reg_e;

	typedef enum logic [0:0] {
		OP_TICK    = 1'b0,
		OP_RESTART = 1'b1
	} opcode_e;

	typedef struct packed {
		logic signed [23:0]  amplitude;
		logic [31:0]         frequency_step;
		logic signed [31:0]  offset;
		logic [15:0]         start_phase;
		logic [31:0]         run_limit_us;
		logic [JOINT_W-1:0]  active_joint;
		logic [COUNT_W-1:0]  joint_count;
	} cfg_t;

	// classified item handed from front to back
	typedef struct packed {
		logic                  live;
		logic                  flag;
		logic [THETA_HI_W-1:0] theta_hi;
	} desc_t;

	// quarter-wave sine entry k of a table of 2^bits + 1 entries, Q30, elaboration use only
	function automatic logic [30:0] qsine(input int unsigned k, input int unsigned bits);
		logic [63:0]        x;
		logic [63:0]        term;
		logic signed [63:0] sum;
		x    = (HALF_PI_Q30 * 64'(k) + ((64'd1 << bits) >> 1)) >> bits;
		term = x;
		sum  = $signed(x);
		term = (((term * x) >> 30) * x) >> 30;
		term = term / 6;
		sum  = sum - $signed(term);
		term = (((term * x) >> 30) * x) >> 30;
		term = term / 20;
		sum  = sum + $signed(term);
		term = (((term * x) >> 30) * x) >> 30;
		term = term / 42;
		sum  = sum - $signed(term);
		term = (((term * x) >> 30) * x) >> 30;
		term = term / 72;
		sum  = sum + $signed(term);
		term = (((term * x) >> 30) * x) >> 30;
		term = term / 110;
		sum  = sum - $signed(term);
		term = (((term * x) >> 30) * x) >> 30;
		term = term / 156;
		sum  = sum + $signed(term);
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > $signed(ONE_Q30)) begin
			sum = $signed(ONE_Q30);
		end
		return 31'(sum);
	endfunction

endpackage

### hw/rtl/tscg_if.sv
// ----------------------------------------------------------------------------
// tscg channel interfaces
// Tick input, command output and configuration write channels.
// ----------------------------------------------------------------------------
interface tscg_tick_if;
	logic                          valid;
	logic                          ready;
	logic                          opcode;
	logic [tscg_pkg::PERIOD_W-1:0] period_us;

	modport source (output valid, output opcode, output period_us, input ready);
	modport sink   (input valid, input opcode, input period_us, output ready);
endinterface

interface tscg_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [tscg_pkg::JOINT_W-1:0] joint_number;
	logic signed [tscg_pkg::CMD_W-1:0] command_value;
	logic                         finished_flag;
	logic                         last_of_tick;

	modport source (output valid, output joint_number, output command_value,
		output finished_flag, output last_of_tick, input ready);
	modport sink   (input valid, input joint_number, input command_value,
		input finished_flag, input last_of_tick, output ready);
endinterface

interface tscg_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [tscg_pkg::CFG_IDX_W-1:0]  index;
	logic [tscg_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/tscg_front.sv
// ----------------------------------------------------------------------------
// tscg_front
// Holds configuration and run state, accepts tick items, classifies them
// and pushes one descriptor per item into the queue.
// ----------------------------------------------------------------------------
module tscg_front (
	input  logic                 clk,
	input  logic                 arst_n,
	tscg_tick_if.sink            tick,
	tscg_cfg_if.sink             cfg,
	input  logic                 q_full,
	output logic                 q_push,
	output tscg_pkg::desc_t      q_data,
	output tscg_pkg::cfg_t       cfg_regs
);

	tscg_pkg::cfg_t                     cfg_q;
	logic [tscg_pkg::PHASE_W-1:0]       phase_acc_q;
	logic [31:0]                        elapsed_q;
	logic                               run_done_q;

	logic                               accept;
	logic                               limit_hit;
	logic [51:0]                        advance;
	logic [32:0]                        elapsed_sum;

	assign cfg.ready  = 1'b1;
	assign tick.ready = !q_full;
	assign accept     = tick.valid && !q_full;
	assign q_push     = accept;
	assign cfg_regs   = cfg_q;

	assign limit_hit   = (cfg_q.run_limit_us != 32'd0) && (elapsed_q >= cfg_q.run_limit_us);
	assign advance     = 52'(cfg_q.frequency_step) * 52'(tick.period_us);
	assign elapsed_sum = {1'b0, elapsed_q} + 33'(tick.period_us);

	always_comb begin
		q_data.live     = 1'b0;
		q_data.flag     = 1'b0;
		// low 32 bits of the start phase are zero, so only the top slice carries
		q_data.theta_hi = cfg_q.start_phase + phase_acc_q[tscg_pkg::PHASE_W-1 -: 16];
		if (tick.opcode == tscg_pkg::OP_RESTART) begin
			q_data.flag = 1'b0;
		end else if (run_done_q || limit_hit) begin
			q_data.flag = 1'b1;
		end else begin
			q_data.live = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.amplitude      <= tscg_pkg::AMPLITUDE_RST;
			cfg_q.frequency_step <= tscg_pkg::FREQ_STEP_RST;
			cfg_q.offset         <= tscg_pkg::OFFSET_RST;
			cfg_q.start_phase    <= tscg_pkg::START_PHASE_RST;
			cfg_q.run_limit_us   <= tscg_pkg::RUN_LIMIT_RST;
			cfg_q.active_joint   <= tscg_pkg::ACTIVE_JOINT_RST;
			cfg_q.joint_count    <= tscg_pkg::JOINT_COUNT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				tscg_pkg::REG_AMPLITUDE:    cfg_q.amplitude      <= $signed(cfg.data[23:0]);
				tscg_pkg::REG_FREQ_STEP:    cfg_q.frequency_step <= cfg.data;
				tscg_pkg::REG_OFFSET:       cfg_q.offset         <= $signed(cfg.data);
				tscg_pkg::REG_START_PHASE:  cfg_q.start_phase    <= cfg.data[15:0];
				tscg_pkg::REG_RUN_LIMIT:    cfg_q.run_limit_us   <= cfg.data;
				tscg_pkg::REG_ACTIVE_JOINT: cfg_q.active_joint   <= cfg.data[tscg_pkg::JOINT_W-1:0];
				tscg_pkg::REG_JOINT_COUNT:  cfg_q.joint_count    <= cfg.data[tscg_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q <= '0;
			elapsed_q   <= '0;
			run_done_q  <= 1'b0;
		end else if (accept) begin
			if (tick.opcode == tscg_pkg::OP_RESTART) begin
				phase_acc_q <= '0;
				elapsed_q   <= '0;
				run_done_q  <= 1'b0;
			end else if (run_done_q || limit_hit) begin
				run_done_q <= 1'b1;
			end else begin
				phase_acc_q <= phase_acc_q + advance[tscg_pkg::PHASE_W-1:0];
				elapsed_q   <= elapsed_sum[32] ? 32'hFFFF_FFFF : elapsed_sum[31:0];
			end
		end
	end

endmodule

### hw/rtl/tscg_queue.sv
// ----------------------------------------------------------------------------
// tscg_queue
// Short descriptor queue between the front and the back end.
// ----------------------------------------------------------------------------
module tscg_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tscg_pkg::desc_t push_data,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output tscg_pkg::desc_t head
);

	tscg_pkg::desc_t                 slots_q [tscg_pkg::QUEUE_DEPTH];
	logic [tscg_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [tscg_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [tscg_pkg::QCNT_W-1:0]     count_q;
	logic                            do_pop;

	assign full   = (count_q == tscg_pkg::QCNT_W'(tscg_pkg::QUEUE_DEPTH));
	assign empty  = (count_q == '0);
	assign head   = slots_q[rd_ptr_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/tscg_back.sv
// ----------------------------------------------------------------------------
// tscg_back
// Sine lookup, scaling, rounding and saturation pipeline, followed by the
// joint sequencer that emits one command per joint in use.
// ----------------------------------------------------------------------------
module tscg_back #(
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tscg_pkg::cfg_t    cfg_regs,
	input  logic              q_empty,
	input  tscg_pkg::desc_t   q_head,
	output logic              q_pop,
	tscg_cmd_if.source        command
);

	localparam int TB = SINE_TABLE_BITS;
	localparam int ROM_LAST = 1 << TB;

	typedef logic [30:0] rom_t [0:ROM_LAST];

	function automatic rom_t build_rom();
		rom_t r;
		for (int k = 0; k <= ROM_LAST; k++) begin
			r[k] = tscg_pkg::qsine(k, TB);
		end
		return r;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	localparam logic [TB:0] N_ADDR = {1'b1, {TB{1'b0}}};

	// address formation
	logic [1:0]    quad;
	logic [TB-1:0] tab_idx;
	logic [TB:0]   rom_addr;

	// pipeline
	logic                v_s1, v_s2, v_s3, v_s4;
	logic                live_s1, live_s2, live_s3;
	logic                flag_s1, flag_s2, flag_s3, flag_s4;
	logic                neg_s1, neg_s2;
	logic [30:0]         rom_s1;
	logic signed [55:0]  prod_s2;
	logic signed [25:0]  r_s3;
	logic signed [31:0]  cmd_s4;
	logic                adv;

	logic signed [55:0]  p_sgn;
	logic signed [55:0]  p_rnd;
	logic signed [33:0]  sum;
	logic signed [31:0]  sat;

	// joint sequencer and output register
	logic                       busy_q;
	logic [tscg_pkg::JOINT_W-1:0] joint_q;
	logic signed [31:0]         cmd_q;
	logic                       flag_q;
	logic                       out_v_q;
	logic [tscg_pkg::COUNT_W-1:0] eff_count;
	logic [tscg_pkg::JOINT_W-1:0] last_joint;
	logic                       out_free;
	logic                       emit;
	logic                       at_last;
	logic                       load_seq;

	assign quad     = q_head.theta_hi[15:14];
	assign tab_idx  = q_head.theta_hi[13 -: TB];
	assign rom_addr = quad[0] ? (N_ADDR - {1'b0, tab_idx}) : {1'b0, tab_idx};

	assign q_pop = adv && !q_empty;

	always_comb begin
		p_sgn = neg_s2 ? -prod_s2 : prod_s2;
		p_rnd = p_sgn + 56'sd536870912;
		sum   = 34'(cfg_regs.offset) + 34'(r_s3);
		if (sum > 34'(tscg_pkg::CMD_MAX)) begin
			sat = tscg_pkg::CMD_MAX;
		end else if (sum < 34'(tscg_pkg::CMD_MIN)) begin
			sat = tscg_pkg::CMD_MIN;
		end else begin
			sat = 32'(sum);
		end
	end

	// whole pipeline moves together, held while the sequencer is full
	assign adv = !v_s4 || load_seq;

	always_ff @(posedge clk) begin
		if (adv) begin
			rom_s1  <= SINE_ROM[rom_addr];
			neg_s1  <= quad[1];
			live_s1 <= q_head.live;
			flag_s1 <= q_head.flag;
			prod_s2 <= 56'(cfg_regs.amplitude) * 56'($signed({1'b0, rom_s1}));
			neg_s2  <= neg_s1;
			live_s2 <= live_s1;
			flag_s2 <= flag_s1;
			r_s3    <= 26'(p_rnd >>> 30);
			live_s3 <= live_s2;
			flag_s3 <= flag_s2;
			cmd_s4  <= live_s3 ? sat : 32'sd0;
			flag_s4 <= flag_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= !q_empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// joint count 0 acts as 1, large counts clamp to the joint limit
	always_comb begin
		if (cfg_regs.joint_count == '0) begin
			eff_count = tscg_pkg::COUNT_W'(1);
		end else if (cfg_regs.joint_count > tscg_pkg::COUNT_W'(tscg_pkg::JOINT_LIMIT)) begin
			eff_count = tscg_pkg::COUNT_W'(tscg_pkg::JOINT_LIMIT);
		end else begin
			eff_count = cfg_regs.joint_count;
		end
		last_joint = tscg_pkg::JOINT_W'(eff_count - 1'b1);
	end

	assign out_free = !out_v_q || command.ready;
	assign emit     = busy_q && out_free;
	assign at_last  = (joint_q == last_joint);
	assign load_seq = v_s4 && (!busy_q || (emit && at_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			joint_q <= '0;
		end else if (load_seq) begin
			busy_q  <= 1'b1;
			joint_q <= '0;
		end else if (emit && at_last) begin
			busy_q <= 1'b0;
		end else if (emit) begin
			joint_q <= joint_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_seq) begin
			cmd_q  <= cmd_s4;
			flag_q <= flag_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (emit) begin
			out_v_q <= 1'b1;
		end else if (command.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			command.joint_number  <= joint_q;
			command.command_value <= (joint_q == cfg_regs.active_joint) ? cmd_q : 32'sd0;
			command.finished_flag <= flag_q;
			command.last_of_tick  <= at_last;
		end
	end

	assign command.valid = out_v_q;

endmodule

### hw/rtl/timed_sine_command_generator.sv
// ----------------------------------------------------------------------------
// timed_sine_command_generator
// Sine velocity command generator driven by timed tick items.
// ----------------------------------------------------------------------------
// Each tick item yields one command per joint in use (1 to 8), one result per
// clock cycle from the joint sequencer while the command output is not held by
// ready; with a single joint a new item is taken every cycle on the same terms.
// An accepted item passes through the queue, table read, multiply, round,
// saturate, sequencer and output register in that order. Up to four classified
// items wait in the queue, so ticks are accepted while the back end drains
// earlier ones. Configuration writes are always accepted.
module timed_sine_command_generator #(
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic         clk,
	input  logic         arst_n,
	tscg_tick_if.sink    tick,
	tscg_cfg_if.sink     cfg,
	tscg_cmd_if.source   command
);

	tscg_pkg::cfg_t  cfg_regs;
	tscg_pkg::desc_t push_data;
	tscg_pkg::desc_t head;
	logic            push;
	logic            full;
	logic            pop;
	logic            empty;

	tscg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tick),
		.cfg      (cfg),
		.q_full   (full),
		.q_push   (push),
		.q_data   (push_data),
		.cfg_regs (cfg_regs)
	);

	tscg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.empty     (empty),
		.head      (head)
	);

	tscg_back #(
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_regs (cfg_regs),
		.q_empty  (empty),
		.q_head   (head),
		.q_pop    (pop),
		.command  (command)
	);

endmodule

### hw/rtl/tscg_checker.sv
// ----------------------------------------------------------------------------
// tscg_checker
// Port-level checks on the command output of the sine command generator.
// ----------------------------------------------------------------------------
module tscg_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [tscg_pkg::JOINT_W-1:0]  joint_number,
	input logic [tscg_pkg::CMD_W-1:0]    command_value,
	input logic                          finished_flag,
	input logic                          last_of_tick
);

	logic [tscg_pkg::JOINT_W-1:0] exp_joint_q;
	logic                         flag_q;

	// expected joint of the next result and flag of the current item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_joint_q <= '0;
			flag_q      <= 1'b0;
		end else if (out_valid && out_ready) begin
			exp_joint_q <= last_of_tick ? '0 : joint_number + 1'b1;
			flag_q      <= finished_flag;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(joint_number)
			&& $stable(command_value) && $stable(finished_flag) && $stable(last_of_tick))
		else $error("command changed while stalled");

	a_finished_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && finished_flag |-> command_value == '0)
		else $error("finished item carries a nonzero command");

	a_joint_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> joint_number == exp_joint_q)
		else $error("joint results out of order");

	a_flag_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && exp_joint_q != '0 |-> finished_flag == flag_q)
		else $error("finished flag changed within an item");

endmodule

bind timed_sine_command_generator tscg_checker u_tscg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (command.valid),
	.out_ready     (command.ready),
	.joint_number  (command.joint_number),
	.command_value (command.command_value),
	.finished_flag (command.finished_flag),
	.last_of_tick  (command.last_of_tick)
);

### bench/timed_sine_command_generator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timed_sine_command_generator_tb
// Self-checking bench for the timed sine command generator. A directed table
// covers reset values, amplitude and offset extremes with saturation, joint
// count clamping, an active joint that is not in use, and the run limit with
// restart. Random phases then reprogram the registers between bursts of ticks,
// and a short run of maximal periods closes the run. Every command is checked
// against a local sine predictor, or against the value that a directed row sets.
// ----------------------------------------------------------------------------
module timed_sine_command_generator_tb;

	localparam int SINE_BITS = 10;
	localparam int QUARTER_N = 1 << SINE_BITS;

	typedef struct {
		logic [tscg_pkg::JOINT_W-1:0]      joint_number;
		logic signed [tscg_pkg::CMD_W-1:0] command_value;
		logic                              finished_flag;
		logic                              last_of_tick;
	} joint_command_t;

	typedef enum logic {
		ROW_CFG,
		ROW_ITEM
	} row_kind_e;

	typedef struct {
		row_kind_e           kind;
		tscg_pkg::cfg_reg_e  idx;
		logic [31:0]         data;
		tscg_pkg::opcode_e   op;
		logic [19:0]         per;
		bit                  typed;
		logic signed [31:0]  cmd;
		bit                  flag;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	tscg_tick_if tick_ch ();
	tscg_cfg_if  cfg_ch ();
	tscg_cmd_if  cmd_ch ();

	timed_sine_command_generator #(
		.SINE_TABLE_BITS(SINE_BITS)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_ch),
		.cfg    (cfg_ch),
		.command(cmd_ch)
	);

	// generator state as the bench sees it
	tscg_pkg::cfg_t gen_cfg;
	logic [47:0]    phase_acc;
	logic [31:0]    elapsed_us;
	logic           run_done;
	longint         quarter_sine [0:QUARTER_N];

	joint_command_t pending_commands[$];
	stim_row_t      directed_rows[$];
	int             mismatch_count = 0;
	bit             steady = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// quarter-wave table in Q30, Taylor series through x^13
	initial begin : build_sine_table
		logic [63:0] x;
		logic [63:0] term;
		longint      series;
		int          k;
		int          j;
		for (k = 0; k <= QUARTER_N; k++) begin
			x = (tscg_pkg::HALF_PI_Q30 * 64'(k) + 64'(QUARTER_N / 2)) >> SINE_BITS;
			term = x;
			series = longint'(x);
			for (j = 1; j <= 6; j++) begin
				term = (term * x) >> 30;
				term = (term * x) >> 30;
				term = term / 64'((2 * j) * (2 * j + 1));
				if (j % 2 == 1) begin
					series -= longint'(term);
				end else begin
					series += longint'(term);
				end
			end
			if (series < 0) begin
				series = 0;
			end
			if (series > longint'(tscg_pkg::ONE_Q30)) begin
				series = longint'(tscg_pkg::ONE_Q30);
			end
			quarter_sine[k] = series;
		end
	end

	function automatic longint sine_q30(logic [47:0] theta);
		int unsigned idx;
		longint      mag;
		idx = theta[45 -: SINE_BITS];
		mag = theta[46] ? quarter_sine[QUARTER_N - idx] : quarter_sine[idx];
		return theta[47] ? -mag : mag;
	endfunction

	function automatic stim_row_t cfg_row(tscg_pkg::cfg_reg_e idx, logic [31:0] data);
		stim_row_t r;
		r.kind = ROW_CFG;
		r.idx = idx;
		r.data = data;
		r.op = tscg_pkg::OP_TICK;
		r.per = '0;
		r.typed = 1'b0;
		r.cmd = '0;
		r.flag = 1'b0;
		return r;
	endfunction

	function automatic stim_row_t item_row(tscg_pkg::opcode_e op, logic [19:0] per,
			bit typed = 1'b0, logic signed [31:0] cmd = '0, bit flag = 1'b0);
		stim_row_t r;
		r.kind = ROW_ITEM;
		r.idx = tscg_pkg::REG_AMPLITUDE;
		r.data = '0;
		r.op = op;
		r.per = per;
		r.typed = typed;
		r.cmd = cmd;
		r.flag = flag;
		return r;
	endfunction

	function automatic void add_row(stim_row_t r);
		directed_rows.insert(directed_rows.size(), r);
	endfunction

	// works out the joint commands of one tick item and advances the state
	task automatic predict_commands(tscg_pkg::opcode_e op, logic [19:0] per, bit typed,
			logic signed [31:0] typed_cmd, bit typed_flag);
		int unsigned        count;
		int unsigned        j;
		bit                 live;
		bit                 flag;
		logic [47:0]        theta;
		longint             product;
		longint             sum;
		logic signed [31:0] shown;
		logic [32:0]        elapsed_next;
		joint_command_t     res;
		count = gen_cfg.joint_count;
		if (count == 0) begin
			count = 1;
		end
		if (count > tscg_pkg::JOINT_LIMIT) begin
			count = tscg_pkg::JOINT_LIMIT;
		end
		live = 1'b0;
		flag = 1'b0;
		shown = '0;
		if (op == tscg_pkg::OP_RESTART) begin
			phase_acc = '0;
			elapsed_us = '0;
			run_done = 1'b0;
		end else if (run_done) begin
			flag = 1'b1;
		end else if (gen_cfg.run_limit_us != 0 && elapsed_us >= gen_cfg.run_limit_us) begin
			run_done = 1'b1;
			flag = 1'b1;
		end else begin
			live = 1'b1;
			theta = {gen_cfg.start_phase, 32'd0} + phase_acc;
			product = longint'($signed(gen_cfg.amplitude)) * sine_q30(theta);
			// round half up, then add the offset and saturate
			sum = ((product + 64'sd536870912) >>> 30) + longint'($signed(gen_cfg.offset));
			if (sum > longint'(tscg_pkg::CMD_MAX)) begin
				sum = longint'(tscg_pkg::CMD_MAX);
			end
			if (sum < longint'(tscg_pkg::CMD_MIN)) begin
				sum = longint'(tscg_pkg::CMD_MIN);
			end
			shown = 32'(sum);
		end
		if (typed) begin
			shown = typed_cmd;
			flag = typed_flag;
		end
		for (j = 0; j < count; j++) begin
			res.joint_number = tscg_pkg::JOINT_W'(j);
			res.command_value = (j == gen_cfg.active_joint) ? shown : '0;
			res.finished_flag = flag;
			res.last_of_tick = (j + 1 == count);
			pending_commands.insert(pending_commands.size(), res);
		end
		if (live) begin
			phase_acc = phase_acc + 48'(64'(gen_cfg.frequency_step) * 64'(per));
			elapsed_next = {1'b0, elapsed_us} + 33'(per);
			elapsed_us = elapsed_next[32] ? 32'hFFFF_FFFF : elapsed_next[31:0];
		end
	endtask

	task automatic send_tick(tscg_pkg::opcode_e op, logic [19:0] per, bit typed = 1'b0,
			logic signed [31:0] typed_cmd = '0, bit typed_flag = 1'b0);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 21) begin
			tick_ch.valid <= 1'b0;
			@(negedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.opcode <= op;
		tick_ch.period_us <= per;
		do @(posedge clk); while (!tick_ch.ready);
		predict_commands(op, per, typed, typed_cmd, typed_flag);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		tick_ch.valid <= 1'b0;
		while (pending_commands.size() != 0) @(posedge clk);
	endtask

	task automatic write_register(tscg_pkg::cfg_reg_e idx, logic [31:0] data);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			tscg_pkg::REG_AMPLITUDE:    gen_cfg.amplitude = data[23:0];
			tscg_pkg::REG_FREQ_STEP:    gen_cfg.frequency_step = data;
			tscg_pkg::REG_OFFSET:       gen_cfg.offset = data;
			tscg_pkg::REG_START_PHASE:  gen_cfg.start_phase = data[15:0];
			tscg_pkg::REG_RUN_LIMIT:    gen_cfg.run_limit_us = data;
			tscg_pkg::REG_ACTIVE_JOINT: gen_cfg.active_joint = data[tscg_pkg::JOINT_W-1:0];
			tscg_pkg::REG_JOINT_COUNT:  gen_cfg.joint_count = data[tscg_pkg::COUNT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	always @(negedge clk) begin
		cmd_ch.ready <= steady || ($urandom_range(0, 99) >= 21);
	end

	always @(posedge clk) begin : check_commands
		joint_command_t want;
		if (arst_n && cmd_ch.valid && cmd_ch.ready) begin
			if (pending_commands.size() == 0) begin
				$error("unexpected command item: joint %0d value %0d",
					cmd_ch.joint_number, cmd_ch.command_value);
				mismatch_count++;
			end else begin
				want = pending_commands.pop_front();
				if (cmd_ch.joint_number !== want.joint_number) begin
					$error("joint_number: expected %0d, got %0d",
						want.joint_number, cmd_ch.joint_number);
					mismatch_count++;
				end
				if (cmd_ch.command_value !== want.command_value) begin
					$error("command_value: expected %0d, got %0d",
						want.command_value, cmd_ch.command_value);
					mismatch_count++;
				end
				if (cmd_ch.finished_flag !== want.finished_flag) begin
					$error("finished_flag: expected %0b, got %0b",
						want.finished_flag, cmd_ch.finished_flag);
					mismatch_count++;
				end
				if (cmd_ch.last_of_tick !== want.last_of_tick) begin
					$error("last_of_tick: expected %0b, got %0b",
						want.last_of_tick, cmd_ch.last_of_tick);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : run_limit_guard
		#20_000_000;
		$display("timed_sine_command_generator verification failed");
		$finish;
	end

	initial begin : stimulus
		logic [31:0]       data;
		tscg_pkg::opcode_e op;
		logic [19:0]       per;
		int                phase;
		int                r;
		int                n;
		arst_n = 1'b0;
		tick_ch.valid = 1'b0;
		tick_ch.opcode = tscg_pkg::OP_TICK;
		tick_ch.period_us = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = tscg_pkg::REG_AMPLITUDE;
		cfg_ch.data = '0;
		gen_cfg.amplitude = tscg_pkg::AMPLITUDE_RST;
		gen_cfg.frequency_step = tscg_pkg::FREQ_STEP_RST;
		gen_cfg.offset = tscg_pkg::OFFSET_RST;
		gen_cfg.start_phase = tscg_pkg::START_PHASE_RST;
		gen_cfg.run_limit_us = tscg_pkg::RUN_LIMIT_RST;
		gen_cfg.active_joint = tscg_pkg::ACTIVE_JOINT_RST;
		gen_cfg.joint_count = tscg_pkg::JOINT_COUNT_RST;
		phase_acc = '0;
		elapsed_us = '0;
		run_done = 1'b0;

		// reset values: phase zero and zero offset give zero
		add_row(item_row(tscg_pkg::OP_TICK, 20'd0, 1'b1, 32'sd0, 1'b0));
		add_row(item_row(tscg_pkg::OP_TICK, 20'hFFFFF, 1'b1, 32'sd0, 1'b0));
		add_row(item_row(tscg_pkg::OP_TICK, 20'd1000));
		add_row(item_row(tscg_pkg::OP_RESTART, 20'hFFFFF, 1'b1, 32'sd0, 1'b0));
		// wave peak on top of the largest offsets saturates both ways
		add_row(cfg_row(tscg_pkg::REG_START_PHASE, 32'h0000_4000));
		add_row(cfg_row(tscg_pkg::REG_AMPLITUDE, 32'h007F_FFFF));
		add_row(cfg_row(tscg_pkg::REG_OFFSET, 32'h7FFF_FFFF));
		add_row(item_row(tscg_pkg::OP_TICK, 20'd0, 1'b1, tscg_pkg::CMD_MAX, 1'b0));
		add_row(cfg_row(tscg_pkg::REG_AMPLITUDE, 32'hFF80_0000));
		add_row(cfg_row(tscg_pkg::REG_OFFSET, 32'h8000_0000));
		add_row(item_row(tscg_pkg::OP_TICK, 20'd0, 1'b1, tscg_pkg::CMD_MIN, 1'b0));
		add_row(cfg_row(tscg_pkg::REG_START_PHASE, 32'h0000_C000));
		add_row(item_row(tscg_pkg::OP_TICK, 20'd0));
		// half turn lands on zero sine, leaving the bare offset
		add_row(cfg_row(tscg_pkg::REG_START_PHASE, 32'h0000_8000));
		add_row(cfg_row(tscg_pkg::REG_OFFSET, 32'd12345));
		add_row(item_row(tscg_pkg::OP_TICK, 20'd0, 1'b1, 32'sd12345, 1'b0));
		// largest step wraps the accumulator
		add_row(cfg_row(tscg_pkg::REG_START_PHASE, 32'h0000_2000));
		add_row(cfg_row(tscg_pkg::REG_AMPLITUDE, 32'd1000));
		add_row(cfg_row(tscg_pkg::REG_OFFSET, 32'd0));
		add_row(cfg_row(tscg_pkg::REG_FREQ_STEP, 32'hFFFF_FFFF));
		add_row(item_row(tscg_pkg::OP_TICK, 20'hFFFFF));
		add_row(item_row(tscg_pkg::OP_TICK, 20'd777));
		add_row(item_row(tscg_pkg::OP_TICK, 20'd3));
		// joint count: full, zero, above the limit, active joint out of range
		add_row(cfg_row(tscg_pkg::REG_JOINT_COUNT, 32'd8));
		add_row(cfg_row(tscg_pkg::REG_ACTIVE_JOINT, 32'd7));
		add_row(item_row(tscg_pkg::OP_TICK, 20'd500));
		add_row(cfg_row(tscg_pkg::REG_JOINT_COUNT, 32'd0));
		add_row(item_row(tscg_pkg::OP_TICK, 20'd500));
		add_row(cfg_row(tscg_pkg::REG_JOINT_COUNT, 32'd15));
		add_row(item_row(tscg_pkg::OP_TICK, 20'd500));
		add_row(cfg_row(tscg_pkg::REG_JOINT_COUNT, 32'd3));
		add_row(cfg_row(tscg_pkg::REG_ACTIVE_JOINT, 32'd5));
		add_row(item_row(tscg_pkg::OP_TICK, 20'd100, 1'b1, 32'sd0, 1'b0));
		add_row(item_row(tscg_pkg::OP_TICK, 20'd100));
		// run limit hit exactly, then held finished until restart
		add_row(cfg_row(tscg_pkg::REG_RUN_LIMIT, 32'd12));
		add_row(cfg_row(tscg_pkg::REG_JOINT_COUNT, 32'd2));
		add_row(cfg_row(tscg_pkg::REG_ACTIVE_JOINT, 32'd1));
		add_row(cfg_row(tscg_pkg::REG_FREQ_STEP, tscg_pkg::FREQ_STEP_RST));
		add_row(item_row(tscg_pkg::OP_RESTART, 20'd0, 1'b1, 32'sd0, 1'b0));
		add_row(item_row(tscg_pkg::OP_TICK, 20'd6));
		add_row(item_row(tscg_pkg::OP_TICK, 20'd6));
		add_row(item_row(tscg_pkg::OP_TICK, 20'd6, 1'b1, 32'sd0, 1'b1));
		add_row(item_row(tscg_pkg::OP_TICK, 20'd6, 1'b1, 32'sd0, 1'b1));
		add_row(item_row(tscg_pkg::OP_RESTART, 20'd6, 1'b1, 32'sd0, 1'b0));
		add_row(item_row(tscg_pkg::OP_TICK, 20'd6));

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[n]) begin
			if (directed_rows[n].kind == ROW_CFG) begin
				wait_drained();
				write_register(directed_rows[n].idx, directed_rows[n].data);
			end else begin
				send_tick(directed_rows[n].op, directed_rows[n].per, directed_rows[n].typed,
					directed_rows[n].cmd, directed_rows[n].flag);
			end
		end

		for (phase = 0; phase < 8; phase++) begin
			wait_drained();
			steady = (phase == 3);
			for (r = 0; r <= int'(tscg_pkg::REG_JOINT_COUNT); r++) begin
				if (phase == 0 || $urandom_range(0, 99) < 60) begin
					data = $urandom();
					case (tscg_pkg::cfg_reg_e'(r))
						tscg_pkg::REG_AMPLITUDE: begin
							case ($urandom_range(0, 5))
								0: data[23:0] = 24'h80_0000;
								1: data[23:0] = 24'h7F_FFFF;
								2: data[23:0] = 24'($urandom_range(0, 5000));
								3: data[23:0] = -24'($urandom_range(0, 5000));
								default: ;
							endcase
						end
						tscg_pkg::REG_FREQ_STEP: begin
							case ($urandom_range(0, 4))
								0: data = '0;
								1: data = 32'hFFFF_FFFF;
								2: data = tscg_pkg::FREQ_STEP_RST;
								default: ;
							endcase
						end
						tscg_pkg::REG_OFFSET: begin
							case ($urandom_range(0, 4))
								0: data = 32'h8000_0000;
								1: data = 32'h7FFF_FFFF;
								2: data = 32'($urandom_range(0, 20000)) - 32'd10000;
								default: ;
							endcase
						end
						tscg_pkg::REG_START_PHASE: begin
							case ($urandom_range(0, 4))
								0: data[15:0] = 16'h0000;
								1: data[15:0] = 16'hFFFF;
								default: ;
							endcase
						end
						tscg_pkg::REG_RUN_LIMIT: begin
							case ($urandom_range(0, 5))
								0, 1: data = '0;
								2, 3: data = $urandom_range(1, 30000);
								4: data = 32'hFFFF_FFFF;
								default: ;
							endcase
						end
						tscg_pkg::REG_JOINT_COUNT: begin
							if ($urandom_range(0, 3) != 0) begin
								data[3:0] = 4'($urandom_range(1, 8));
							end
						end
						default: ;
					endcase
					write_register(tscg_pkg::cfg_reg_e'(r), data);
				end
			end
			for (n = 0; n < 36; n++) begin
				op = ($urandom_range(0, 99) < 8) ? tscg_pkg::OP_RESTART : tscg_pkg::OP_TICK;
				case ($urandom_range(0, 9))
					0: per = '0;
					1: per = 20'hFFFFF;
					2, 3: per = 20'($urandom());
					default: per = 20'($urandom_range(1, 2000));
				endcase
				send_tick(op, per);
			end
		end
		steady = 1'b0;

		// a few maximal periods against the largest run limit
		wait_drained();
		write_register(tscg_pkg::REG_RUN_LIMIT, 32'hFFFF_FFFF);
		write_register(tscg_pkg::REG_JOINT_COUNT, 32'd1);
		send_tick(tscg_pkg::OP_RESTART, 20'd0);
		repeat (4) send_tick(tscg_pkg::OP_TICK, 20'hFFFFF);

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("timed_sine_command_generator verification clean");
		end else begin
			$display("timed_sine_command_generator verification failed");
		end
		$finish;
	end

endmodule
